// ----- rtl/core/olbc_pkg.sv -----
package olbc_pkg;

  localparam int MAX_ON_BRIDGE = 16;
  localparam int QUEUE_BITS    = 8;
  localparam int CNT_W         = $clog2(MAX_ON_BRIDGE + 1);
  localparam int TIMER_W       = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [QUEUE_BITS-1:0] QUEUE_MAX = {QUEUE_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      BRIDGE_FULL = CNT_W'(MAX_ON_BRIDGE);

  localparam logic [TIMER_W-1:0] ENTRY_DELAY_RST = TIMER_W'(1000);
  localparam logic [TIMER_W-1:0] DRIVE_TIME_RST  = TIMER_W'(5000);

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_TIME  = CFG_IDX_W'(1);

  localparam logic KIND_SENSOR = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam int NORTH_BIT = 7;
  localparam int SOUTH_BIT = 5;

  localparam logic SIDE_NORTH = 1'b0;
  localparam logic SIDE_SOUTH = 1'b1;

  typedef enum logic [1:0] {
    DIR_OPEN_NORTH   = 2'd0,
    DIR_OPEN_SOUTH   = 2'd1,
    DIR_CLOSED_NORTH = 2'd2,
    DIR_CLOSED_SOUTH = 2'd3
  } dir_t;

endpackage

// ----- rtl/core/one_lane_bridge_controller.sv -----
// One-lane bridge controller. Takes one request per clock (sensor byte or
// time tick) and returns one result per request. The accepting edge loads
// the input register; the request waits there until the result side can
// advance, and then moves through the update logic into the state and result
// registers. All counters, the poll countdown and the 16 car timers update
// together in that same step, so the sustained rate is one request per cycle
// whenever the result side does not stall. Configuration
// writes (entry delay, drive time) are always ready; cfg_index values beyond
// the two registers are ignored.
module one_lane_bridge_controller import olbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [7:0]            in_sensor_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_admitted,
  output logic                  out_admit_south,
  output logic [QUEUE_BITS-1:0] out_north_waiting,
  output logic [QUEUE_BITS-1:0] out_south_waiting,
  output logic [CNT_W-1:0]      out_cars_on_bridge,
  output logic [1:0]            out_bridge_direction,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIMER_W-1:0]    cfg_data
);

  logic [TIMER_W-1:0]    entry_delay_r;
  logic [TIMER_W-1:0]    drive_time_r;

  logic                  s1_valid_r;
  logic                  s1_kind_r;
  logic [7:0]            s1_sensor_r;

  logic [QUEUE_BITS-1:0] north_r, north_nxt;
  logic [QUEUE_BITS-1:0] south_r, south_nxt;
  logic [CNT_W-1:0]      bridge_r, bridge_nxt;
  dir_t                  dir_r, dir_nxt;
  logic                  pref_r, pref_nxt;
  logic [TIMER_W-1:0]    poll_r, poll_nxt;
  logic [TIMER_W-1:0]    timer_r   [MAX_ON_BRIDGE];
  logic [TIMER_W-1:0]    timer_nxt [MAX_ON_BRIDGE];

  logic                  out_valid_r;
  logic                  admitted_r, admitted_nxt;
  logic                  admit_south_r, admit_south_nxt;

  logic                  advance, go;

  logic [TIMER_W-1:0]    timer_dec [MAX_ON_BRIDGE];
  logic [MAX_ON_BRIDGE-1:0] expire, busy, long_run, free_slot, first_free;
  logic [CNT_W-1:0]      bridge_tick;
  logic                  pref_tick;
  logic [TIMER_W-1:0]    poll_dec;
  logic [TIMER_W-1:0]    entry_reload, drive_load;
  logic                  poll_now;
  logic                  want, pick;
  dir_t                  dir_poll;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_delay_r <= ENTRY_DELAY_RST;
      drive_time_r  <= DRIVE_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ENTRY_DELAY) begin
        entry_delay_r <= cfg_data;
      end
      if (cfg_index == CFG_DRIVE_TIME) begin
        drive_time_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind_r   <= in_kind;
      s1_sensor_r <= in_sensor_byte;
    end
  end

  // timer update shared by every tick
  always_comb begin
    for (int i = 0; i < MAX_ON_BRIDGE; i++) begin
      busy[i]      = timer_r[i] != '0;
      expire[i]    = timer_r[i] == TIMER_W'(1);
      long_run[i]  = busy[i] && !expire[i];
      timer_dec[i] = busy[i] ? timer_r[i] - TIMER_W'(1) : timer_r[i];
      free_slot[i] = !long_run[i];
    end
  end

  assign first_free   = free_slot & (~free_slot + MAX_ON_BRIDGE'(1));
  assign bridge_tick  = bridge_r - CNT_W'($countones(expire));
  assign pref_tick    = pref_r ^ ((|busy) && !(|long_run));
  assign poll_dec     = (poll_r != '0) ? poll_r - TIMER_W'(1) : poll_r;
  assign poll_now     = poll_dec == '0;
  assign entry_reload = (entry_delay_r == '0) ? TIMER_W'(1) : entry_delay_r;
  assign drive_load   = (drive_time_r == '0) ? TIMER_W'(1) : drive_time_r;

  // admission decision after the tick's retirements
  always_comb begin
    want     = 1'b0;
    pick     = SIDE_NORTH;
    dir_poll = dir_r;
    if (bridge_tick == '0) begin
      if ((pref_tick ? south_r : north_r) != '0) begin
        want = 1'b1;
        pick = pref_tick;
      end else if ((pref_tick ? north_r : south_r) != '0) begin
        want = 1'b1;
        pick = !pref_tick;
      end
      if (want) begin
        dir_poll = pick ? DIR_OPEN_SOUTH : DIR_OPEN_NORTH;
      end
    end else begin
      case (dir_r)
        DIR_OPEN_NORTH: begin
          if (north_r != '0) begin
            want = bridge_tick < BRIDGE_FULL;
            pick = SIDE_NORTH;
          end else if (south_r != '0) begin
            dir_poll = DIR_CLOSED_NORTH;
          end
        end
        DIR_OPEN_SOUTH: begin
          if (south_r != '0) begin
            want = bridge_tick < BRIDGE_FULL;
            pick = SIDE_SOUTH;
          end else if (north_r != '0) begin
            dir_poll = DIR_CLOSED_SOUTH;
          end
        end
        default: begin
          dir_poll = dir_r;
        end
      endcase
    end
  end

  always_comb begin
    north_nxt       = north_r;
    south_nxt       = south_r;
    bridge_nxt      = bridge_r;
    dir_nxt         = dir_r;
    pref_nxt        = pref_r;
    poll_nxt        = poll_r;
    timer_nxt       = timer_r;
    admitted_nxt    = 1'b0;
    admit_south_nxt = 1'b0;
    if (s1_kind_r == KIND_SENSOR) begin
      if (s1_sensor_r[NORTH_BIT] && north_r != QUEUE_MAX) begin
        north_nxt = north_r + QUEUE_BITS'(1);
      end
      if (s1_sensor_r[SOUTH_BIT] && south_r != QUEUE_MAX) begin
        south_nxt = south_r + QUEUE_BITS'(1);
      end
    end else begin
      timer_nxt  = timer_dec;
      bridge_nxt = bridge_tick;
      pref_nxt   = pref_tick;
      poll_nxt   = poll_dec;
      if (poll_now) begin
        poll_nxt = entry_reload;
        dir_nxt  = dir_poll;
        if (want) begin
          admitted_nxt    = 1'b1;
          admit_south_nxt = pick;
          bridge_nxt      = bridge_tick + CNT_W'(1);
          if (pick) begin
            south_nxt = south_r - QUEUE_BITS'(1);
          end else begin
            north_nxt = north_r - QUEUE_BITS'(1);
          end
          for (int i = 0; i < MAX_ON_BRIDGE; i++) begin
            if (first_free[i]) begin
              timer_nxt[i] = drive_load;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      north_r  <= '0;
      south_r  <= '0;
      bridge_r <= '0;
      dir_r    <= DIR_OPEN_NORTH;
      pref_r   <= SIDE_NORTH;
      poll_r   <= ENTRY_DELAY_RST;
      for (int i = 0; i < MAX_ON_BRIDGE; i++) begin
        timer_r[i] <= '0;
      end
    end else if (go) begin
      north_r  <= north_nxt;
      south_r  <= south_nxt;
      bridge_r <= bridge_nxt;
      dir_r    <= dir_nxt;
      pref_r   <= pref_nxt;
      poll_r   <= poll_nxt;
      timer_r  <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      admitted_r    <= admitted_nxt;
      admit_south_r <= admit_south_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_admitted         = admitted_r;
  assign out_admit_south      = admit_south_r;
  assign out_north_waiting    = north_r;
  assign out_south_waiting    = south_r;
  assign out_cars_on_bridge   = bridge_r;
  assign out_bridge_direction = dir_r;

endmodule

// ----- rtl/core/olbc_checker.sv -----
module olbc_checker import olbc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_admitted,
  input logic                  out_admit_south,
  input logic [CNT_W-1:0]      out_cars_on_bridge,
  input logic [1:0]            out_bridge_direction
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_admitted)
      && $stable(out_cars_on_bridge) && $stable(out_bridge_direction))
    else $error("stalled result changed");

  a_bridge_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cars_on_bridge <= BRIDGE_FULL)
    else $error("too many cars on bridge");

  a_side_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_admitted |-> !out_admit_south)
    else $error("side reported without admission");

  a_admit_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_admitted |->
      out_cars_on_bridge != '0 &&
      ((!out_admit_south && out_bridge_direction == DIR_OPEN_NORTH) ||
       (out_admit_south && out_bridge_direction == DIR_OPEN_SOUTH)))
    else $error("admission does not match open direction");

endmodule

bind one_lane_bridge_controller olbc_checker u_olbc_checker (.*);

// ----- bench/one_lane_bridge_controller_test.sv -----
`timescale 1ns / 100ps

module one_lane_bridge_controller_test;
  import olbc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  typedef struct {
    logic                  admitted;
    logic                  admit_south;
    logic [QUEUE_BITS-1:0] north_waiting;
    logic [QUEUE_BITS-1:0] south_waiting;
    logic [CNT_W-1:0]      cars_on_bridge;
    dir_t                  bridge_direction;
  } bridge_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kind;
  logic [7:0]            in_sensor_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_admitted;
  logic                  out_admit_south;
  logic [QUEUE_BITS-1:0] out_north_waiting;
  logic [QUEUE_BITS-1:0] out_south_waiting;
  logic [CNT_W-1:0]      out_cars_on_bridge;
  logic [1:0]            out_bridge_direction;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [TIMER_W-1:0]    cfg_data;

  // shadow of the controller
  logic [QUEUE_BITS-1:0] north_q;
  logic [QUEUE_BITS-1:0] south_q;
  logic [CNT_W-1:0]      on_bridge;
  dir_t                  heading;
  logic                  favored_south;
  int unsigned           poll_left;
  int unsigned           slot_timer [MAX_ON_BRIDGE];
  logic [TIMER_W-1:0]    poll_period;
  logic [TIMER_W-1:0]    crossing_time;

  bridge_report_t pending_reports [$];
  bridge_report_t head_report;
  int             mismatches = 0;
  bit             calm_period = 1'b0;

  one_lane_bridge_controller dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_sensor_byte       (in_sensor_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_admitted         (out_admitted),
    .out_admit_south      (out_admit_south),
    .out_north_waiting    (out_north_waiting),
    .out_south_waiting    (out_south_waiting),
    .out_cars_on_bridge   (out_cars_on_bridge),
    .out_bridge_direction (out_bridge_direction),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit try_admit(input logic south);
    int i;
    if (on_bridge >= MAX_ON_BRIDGE) return 1'b0;
    for (i = 0; i < MAX_ON_BRIDGE; i++) begin
      if (slot_timer[i] == 0) begin
        slot_timer[i] = (crossing_time == 0) ? 1 : 32'(crossing_time);
        on_bridge++;
        if (south == SIDE_SOUTH) south_q--;
        else north_q--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit run_poll(output logic side);
    logic first;
    logic pick;
    side = SIDE_NORTH;
    if (on_bridge == 0) begin
      first = favored_south;
      if (((first == SIDE_SOUTH) ? south_q : north_q) != 0) pick = first;
      else if (((first == SIDE_SOUTH) ? north_q : south_q) != 0) pick = ~first;
      else return 1'b0;
      if (!try_admit(pick)) return 1'b0;
      heading = (pick == SIDE_SOUTH) ? DIR_OPEN_SOUTH : DIR_OPEN_NORTH;
      side = pick;
      return 1'b1;
    end
    case (heading)
      DIR_OPEN_NORTH: begin
        if (north_q != 0) begin
          if (try_admit(SIDE_NORTH)) begin
            side = SIDE_NORTH;
            return 1'b1;
          end
        end else if (south_q != 0) begin
          heading = DIR_CLOSED_NORTH;
        end
      end
      DIR_OPEN_SOUTH: begin
        if (south_q != 0) begin
          if (try_admit(SIDE_SOUTH)) begin
            side = SIDE_SOUTH;
            return 1'b1;
          end
        end else if (north_q != 0) begin
          heading = DIR_CLOSED_SOUTH;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void advance_bridge(input logic kind, input logic [7:0] sensor);
    bridge_report_t rep;
    logic           got;
    logic           side;
    int             i;
    got  = 1'b0;
    side = SIDE_NORTH;
    if (kind == KIND_SENSOR) begin
      if (sensor[NORTH_BIT] && north_q != QUEUE_MAX) north_q++;
      if (sensor[SOUTH_BIT] && south_q != QUEUE_MAX) south_q++;
    end else begin
      for (i = 0; i < MAX_ON_BRIDGE; i++) begin
        if (slot_timer[i] != 0) begin
          slot_timer[i]--;
          if (slot_timer[i] == 0 && on_bridge != 0) begin
            on_bridge--;
            if (on_bridge == 0) favored_south = ~favored_south;
          end
        end
      end
      if (poll_left > 0) poll_left--;
      if (poll_left == 0) begin
        got = run_poll(side);
        poll_left = (poll_period == 0) ? 1 : 32'(poll_period);
      end
    end
    rep.admitted         = got;
    rep.admit_south      = got ? side : SIDE_NORTH;
    rep.north_waiting    = north_q;
    rep.south_waiting    = south_q;
    rep.cars_on_bridge   = on_bridge;
    rep.bridge_direction = heading;
    pending_reports.push_back(rep);
  endfunction

  function automatic int draw_wait();
    if (calm_period || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 6);
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        head_report = pending_reports.pop_front();
        check_field("admitted", 8'(head_report.admitted), 8'(out_admitted));
        check_field("admit_south", 8'(head_report.admit_south), 8'(out_admit_south));
        check_field("north_waiting", 8'(head_report.north_waiting),
                    8'(out_north_waiting));
        check_field("south_waiting", 8'(head_report.south_waiting),
                    8'(out_south_waiting));
        check_field("cars_on_bridge", 8'(head_report.cars_on_bridge),
                    8'(out_cars_on_bridge));
        check_field("bridge_direction", 8'(head_report.bridge_direction),
                    8'(out_bridge_direction));
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_stall <= 1'b0;
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
    end
  end

  task automatic send_request(input logic kind, input logic [7:0] sensor);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_sensor_byte <= sensor;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_bridge(kind, sensor);
  endtask

  task automatic send_random_item(input int tick_pct);
    logic [7:0] sensor;
    sensor = 8'($urandom);
    if ($urandom_range(0, 99) < tick_pct) begin
      send_request(KIND_TICK, sensor);
    end else begin
      if ($urandom_range(0, 1)) sensor[NORTH_BIT] = 1'b1;
      if ($urandom_range(0, 1)) sensor[SOUTH_BIT] = 1'b1;
      send_request(KIND_SENSOR, sensor);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [TIMER_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENTRY_DELAY: poll_period = value;
      CFG_DRIVE_TIME:  crossing_time = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_sensor_edges();
    send_request(KIND_SENSOR, 8'h00);
    send_request(KIND_SENSOR, 8'h80);
    send_request(KIND_SENSOR, 8'h20);
    send_request(KIND_SENSOR, 8'hA0);
    send_request(KIND_SENSOR, 8'h5F);
    send_request(KIND_SENSOR, 8'hFF);
    send_request(KIND_TICK, 8'h00);
    send_request(KIND_TICK, 8'hFF);
  endtask

  // reset countdown runs out only after the default delay
  task automatic test_first_poll();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd2);
    write_register(CFG_DRIVE_TIME, 16'd5);
    for (n = 0; n < 1000; n++) begin
      calm_period = (n < 300);
      send_request(KIND_TICK, 8'($urandom));
    end
    calm_period = 1'b0;
  endtask

  task automatic test_direction_rules();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd1);
    write_register(CFG_DRIVE_TIME, 16'd3);
    for (n = 0; n < 4; n++) send_request(KIND_TICK, 8'h00);
    send_request(KIND_SENSOR, 8'h20);
    send_request(KIND_SENSOR, 8'h80);
    for (n = 0; n < 6; n++) send_request(KIND_TICK, 8'h00);
    send_request(KIND_SENSOR, 8'h80);
    for (n = 0; n < 3; n++) send_request(KIND_TICK, 8'hFF);
  endtask

  task automatic test_bridge_full();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd1);
    write_register(CFG_DRIVE_TIME, 16'd24);
    for (n = 0; n < 16; n++) send_request(KIND_SENSOR, (8'($urandom) & 8'h5F) | 8'h80);
    for (n = 0; n < 20; n++) send_request(KIND_TICK, 8'($urandom));
    send_request(KIND_SENSOR, 8'h20);
    for (n = 0; n < 3; n++) send_request(KIND_TICK, 8'($urandom));
    send_request(KIND_SENSOR, 8'h80);
    send_request(KIND_SENSOR, 8'h80);
    for (n = 0; n < 30; n++) send_request(KIND_TICK, 8'($urandom));
  endtask

  task automatic test_zero_delays();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd0);
    write_register(CFG_DRIVE_TIME, 16'd0);
    for (n = 0; n < 24; n++) send_random_item(50);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int hold;
    int tick_pct;
    for (phase = 0; phase < 3; phase++) begin
      drain_results();
      calm_period = (phase % 3 == 0);
      write_register(CFG_ENTRY_DELAY,
                     (phase == 2) ? 16'($urandom_range(5, 20)) : 16'($urandom_range(1, 4)));
      write_register(CFG_DRIVE_TIME, 16'($urandom_range(1, 24)));
      tick_pct = $urandom_range(40, 70);
      hold     = $urandom_range(0, 19);
      for (n = 0; n < 20; n++) begin
        if (n == hold && phase % 2 == 0) drain_results();
        send_random_item(tick_pct);
      end
    end
    calm_period = 1'b0;
  endtask

  task automatic test_spare_registers();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd2);
    write_register(CFG_DRIVE_TIME, 16'd7);
    write_register(CFG_SPARE_A, 16'($urandom));
    write_register(CFG_SPARE_B, 16'($urandom));
    for (n = 0; n < 16; n++) send_random_item(55);
  endtask

  task automatic test_queue_saturation();
    int n;
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'd1);
    write_register(CFG_DRIVE_TIME, 16'd1);
    for (n = 0; n < 258; n++) send_request(KIND_SENSOR, 8'($urandom) | 8'hA0);
    for (n = 0; n < 6; n++) send_random_item(60);
  endtask

  task automatic test_long_delays();
    int n;
    drain_results();
    write_register(CFG_DRIVE_TIME, 16'hFFFF);
    write_register(CFG_ENTRY_DELAY, 16'd1);
    for (n = 0; n < 8; n++) send_random_item(60);
    drain_results();
    write_register(CFG_ENTRY_DELAY, 16'hFFFF);
    for (n = 0; n < 12; n++) send_random_item(70);
  endtask

  initial begin
    int i;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_SENSOR;
    in_sensor_byte <= 8'h00;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_ENTRY_DELAY;
    cfg_data       <= '0;
    north_q       = '0;
    south_q       = '0;
    on_bridge     = '0;
    heading       = DIR_OPEN_NORTH;
    favored_south = SIDE_NORTH;
    poll_period   = ENTRY_DELAY_RST;
    crossing_time = DRIVE_TIME_RST;
    poll_left     = 32'(ENTRY_DELAY_RST);
    for (i = 0; i < MAX_ON_BRIDGE; i++) slot_timer[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sensor_edges();
    test_first_poll();
    test_direction_rules();
    test_bridge_full();
    test_zero_delays();
    test_random_traffic();
    test_spare_registers();
    test_queue_saturation();
    test_long_delays();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
